// ----- rtl/core/stream_find_replace_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the stream find-and-replace core
// Shared property wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef STREAM_FIND_REPLACE_CORE_MACROS_SVH
`define STREAM_FIND_REPLACE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising edge outside reset.
`define SFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`else

`define SFR_ASSERT_IMP(lbl, ante, cons)
`define SFR_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/sfr_pkg.sv -----
// ----------------------------------------------------------------------------
// sfr_pkg
// Types and constants shared by the find-and-replace front, queue and back.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int RUN_BYTES       = 8;   // most bytes one input can produce
  localparam int HOLD_DEPTH      = 7;   // held pattern-prefix bytes
  localparam int QUEUE_DEPTH     = 2;
  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [1:0] {
    REG_PATTERN  = 2'd0,
    REG_PAT_LEN  = 2'd1,
    REG_REPL     = 2'd2,
    REG_REPL_LEN = 2'd3
  } cfg_reg_t;

  // One run of output bytes caused by a single input byte.
  typedef struct packed {
    logic [RUN_BYTES-1:0][7:0] data;
    logic [3:0]                count;
  } job_t;

  typedef struct packed {
    logic push;
    job_t job;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/core/sfr_front.sv -----
// ----------------------------------------------------------------------------
// sfr_front
// Accepts input bytes, tracks the held pattern prefix and builds output runs.
// ----------------------------------------------------------------------------
module sfr_front #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_wdata,
  input  logic             in_push,
  input  logic [7:0]       in_data_byte,
  input  logic             in_end_of_input,
  input  sfr_pkg::q_stat_t q_stat,
  output sfr_pkg::q_wr_t   q_wr,
  output logic [2:0]       held_count
);
  import sfr_pkg::*;

  localparam logic [3:0] PAT_CAP  =
    4'((MAX_PATTERN < RUN_BYTES) ? MAX_PATTERN : RUN_BYTES);
  localparam logic [3:0] REPL_CAP =
    4'((MAX_REPLACEMENT < RUN_BYTES) ? MAX_REPLACEMENT : RUN_BYTES);

  logic [RUN_BYTES-1:0][7:0] pattern_r;
  logic [RUN_BYTES-1:0][7:0] repl_r;
  logic [3:0]                pat_len_r;
  logic [3:0]                repl_len_r;

  logic [7:0] held_r [HOLD_DEPTH];
  logic [7:0] held_nxt [HOLD_DEPTH];
  logic [2:0] held_count_r;
  logic [2:0] held_count_nxt;

  logic                      accept;
  logic                      is_newline;
  logic                      full_match;
  logic [3:0]                len;
  logic [3:0]                rl;
  logic [3:0]                cnt;
  logic [3:0]                start;
  logic [RUN_BYTES-1:0][7:0] buf_b;
  logic [RUN_BYTES:0]        tail_ok;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r  <= '0;
      pat_len_r  <= 4'd1;
      repl_r     <= '0;
      repl_len_r <= 4'd0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN:  pattern_r  <= cfg_wdata;
        REG_PAT_LEN:  pat_len_r  <= cfg_wdata[3:0];
        REG_REPL:     repl_r     <= cfg_wdata;
        REG_REPL_LEN: repl_len_r <= cfg_wdata[3:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    len = pat_len_r;
    if (len == 4'd0) len = 4'd1;
    if (len > PAT_CAP) len = PAT_CAP;
    rl = (repl_len_r > REPL_CAP) ? REPL_CAP : repl_len_r;
  end

  assign accept     = in_push && !q_stat.full;
  assign is_newline = (in_data_byte == NEWLINE_BYTE);
  assign cnt        = {1'b0, held_count_r} + 4'd1;

  // Held bytes followed by the new byte.
  always_comb begin
    for (int i = 0; i < RUN_BYTES; i++) begin
      buf_b[i] = (i == int'(held_count_r)) ? in_data_byte : 8'h00;
    end
    for (int i = 0; i < HOLD_DEPTH; i++) begin
      if (i < int'(held_count_r)) buf_b[i] = held_r[i];
    end
  end

  // Every tail of the buffer is checked in parallel for being a proper
  // pattern prefix; the longest qualifying tail is kept.
  always_comb begin
    full_match = (cnt == len);
    for (int j = 0; j < RUN_BYTES; j++) begin
      if (j < int'(cnt) && buf_b[j] != pattern_r[j]) full_match = 1'b0;
    end
    for (int s = 0; s <= RUN_BYTES; s++) begin
      tail_ok[s] = (s <= int'(cnt)) && ((int'(cnt) - s) < int'(len));
      for (int j = 0; j < RUN_BYTES; j++) begin
        if ((s + j) < RUN_BYTES && j < (int'(cnt) - s)
            && buf_b[(s + j) % RUN_BYTES] != pattern_r[j]) begin
          tail_ok[s] = 1'b0;
        end
      end
    end
    start = 4'(RUN_BYTES);
    for (int s = RUN_BYTES; s >= 0; s--) begin
      if (tail_ok[s]) start = 4'(s);
    end
  end

  always_comb begin
    q_wr.job.data = full_match && !is_newline ? repl_r : buf_b;
    if (is_newline || in_end_of_input) begin
      q_wr.job.count = full_match && !is_newline ? rl : cnt;
    end else if (full_match) begin
      q_wr.job.count = rl;
    end else begin
      q_wr.job.count = start;
    end
    q_wr.push = accept && (q_wr.job.count != 4'd0);
  end

  always_comb begin
    for (int k = 0; k < HOLD_DEPTH; k++) begin
      held_nxt[k] = held_r[k];
      if ((int'(start) + k) < RUN_BYTES) begin
        held_nxt[k] = buf_b[(int'(start) + k) % RUN_BYTES];
      end
    end
    if (is_newline || in_end_of_input || full_match) begin
      held_count_nxt = 3'd0;
    end else begin
      held_count_nxt = 3'(cnt - start);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= 3'd0;
    end else if (accept) begin
      held_count_r <= held_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_r <= held_nxt;
    end
  end

  assign held_count = held_count_r;

endmodule

// ----- rtl/core/sfr_queue.sv -----
// ----------------------------------------------------------------------------
// sfr_queue
// Short queue of output runs between the front and the back.
// ----------------------------------------------------------------------------
module sfr_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::q_wr_t   q_wr,
  input  logic             q_pop,
  output sfr_pkg::job_t    q_head,
  output sfr_pkg::q_stat_t q_stat,
  output logic [$clog2(sfr_pkg::QUEUE_DEPTH+1)-1:0] q_count
);
  import sfr_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] count_nxt;
  logic          do_wr;
  logic          do_rd;

  assign q_stat.full  = (count_r == CW'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_wr        = q_wr.push && !q_stat.full;
  assign do_rd        = q_pop && !q_stat.empty;
  assign q_head       = mem_r[rd_ptr_r];
  assign q_count      = count_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= q_wr.job;
    end
  end

endmodule

// ----- rtl/core/sfr_back.sv -----
// ----------------------------------------------------------------------------
// sfr_back
// Plays out the bytes of each queued run, one transaction per byte.
// ----------------------------------------------------------------------------
module sfr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  sfr_pkg::job_t    q_head,
  input  sfr_pkg::q_stat_t q_stat,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_byte,
  output logic             out_last_of_run
);
  import sfr_pkg::*;

  job_t       cur_r;
  logic       busy_r;
  logic [2:0] idx_r;
  logic       busy_nxt;
  logic [2:0] idx_nxt;
  logic       done;

  assign out_empty       = !busy_r;
  assign out_byte        = cur_r.data[idx_r];
  assign out_last_of_run = ({1'b0, idx_r} == (cur_r.count - 4'd1));

  assign done  = out_pop && busy_r && out_last_of_run;
  assign q_pop = (!busy_r || done) && !q_stat.empty;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      idx_nxt  = 3'd0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (out_pop && busy_r) begin
      idx_nxt = idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_head;
    end
  end

endmodule

// ----- rtl/core/stream_find_replace_core.sv -----
// ----------------------------------------------------------------------------
// stream_find_replace_core
// Streaming find-and-replace over a byte stream with a configurable pattern.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  input     in_push / in_full     in_data_byte, in_end_of_input
//  result    out_pop / out_empty   out_byte, out_last_of_run
//  config    cfg_we                cfg_index, cfg_wdata
//
//  An input byte is classified in the cycle it is accepted; a non-empty output
//  run (1 to 8 bytes) enters a two-entry run queue, an empty run is dropped.
//  The back end delivers one byte per cycle while out_pop is held, so input
//  is accepted at one byte per cycle while runs stay at one byte and the
//  output keeps popping.
//  Reset is synchronous; there is no clearing pass.
//  in_full rises only when the run queue is full.
// ----------------------------------------------------------------------------
module stream_find_replace_core #(
  parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_of_input,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_byte,
  output logic        out_last_of_run
);
  import sfr_pkg::*;

  `include "stream_find_replace_core_macros.svh"

  q_wr_t      q_wr;
  q_stat_t    q_stat;
  job_t       q_head;
  logic       q_pop;
  logic [2:0] held_count;
  logic       run_done;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

  assign in_full  = q_stat.full;
  assign run_done = out_pop && !out_empty && out_last_of_run;

  sfr_front #(
    .MAX_PATTERN    (MAX_PATTERN),
    .MAX_REPLACEMENT(MAX_REPLACEMENT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_data_byte   (in_data_byte),
    .in_end_of_input(in_end_of_input),
    .q_stat         (q_stat),
    .q_wr           (q_wr),
    .held_count     (held_count)
  );

  sfr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat),
    .q_count(q_count)
  );

  sfr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run)
  );

  // A run that enters the queue always carries at least one byte.
  `SFR_ASSERT_IMP(a_run_not_empty, q_wr.push, q_wr.job.count != 4'd0)
  // Nothing stays held after the final byte of the input.
  `SFR_ASSERT_NXT(a_eoi_flush, in_push && !in_full && in_end_of_input, held_count == 3'd0)
  // The queue occupancy never passes its depth.
  `SFR_ASSERT_IMP(a_queue_bound, 1'b1, q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
  // Finishing a run with nothing queued or arriving leaves the output empty.
  `SFR_ASSERT_NXT(a_drain, run_done && q_stat.empty && !q_wr.push, out_empty)

endmodule

// ----- tb/stream_find_replace_core_tb.sv -----
// ----------------------------------------------------------------------------
// stream_find_replace_core_tb
// Self-checking testbench for the streaming find-and-replace core. Bytes are
// pushed through the input port and each transaction is run through a
// behavioral model of the pattern hold. That model expects the rewritten
// bytes, which are then compared as they are popped. A directed opening covers
// matches, deletion, newline flushes, length saturation and reconfiguration
// with bytes still held. Random phases follow, with pattern-rich traffic under
// changing settings and random stalls on both sides.
// ----------------------------------------------------------------------------
module stream_find_replace_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfr_pkg::*;

  localparam int HOLD_CYCLES    = 120;
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_ITEMS    = 32;
  localparam int PRESSURE_PHASE = 2;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  class rewrite_scoreboard;
    logic [63:0] pattern_word;
    logic [3:0]  pattern_len_reg;
    logic [63:0] repl_word;
    logic [3:0]  repl_len_reg;
    logic [7:0]  hold [HOLD_DEPTH];
    logic [7:0]  window [RUN_BYTES];
    int unsigned hold_cnt;
    out_beat_t   expected_q[$];
    int          errors;
    int          match_count;
    int          checked;
    int          items;

    function new();
      pattern_word    = '0;
      pattern_len_reg = 4'd1;
      repl_word       = '0;
      repl_len_reg    = 4'd0;
      hold_cnt        = 0;
      errors          = 0;
      match_count     = 0;
      checked         = 0;
      items           = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [63:0] value);
      case (idx)
        REG_PATTERN:  pattern_word    = value;
        REG_PAT_LEN:  pattern_len_reg = value[3:0];
        REG_REPL:     repl_word       = value;
        REG_REPL_LEN: repl_len_reg    = value[3:0];
        default: ;
      endcase
    endfunction

    function bit is_prefix(int unsigned first, int unsigned n);
      for (int unsigned i = 0; i < n; i++) begin
        if (window[first + i] != pattern_word[8*i +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    // Predicts the run of bytes caused by one accepted input transaction.
    function void note_input(logic [7:0] data, logic eoi);
      logic [7:0]  run[$];
      int unsigned plen;
      int unsigned rlen;
      int unsigned cnt;
      int unsigned first;
      int unsigned rest;
      int unsigned cap_p;
      int unsigned cap_r;
      cap_p = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
      cap_r = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;
      plen  = (pattern_len_reg == 0) ? 1 : pattern_len_reg;
      if (plen > cap_p) plen = cap_p;
      rlen  = (repl_len_reg > cap_r) ? cap_r : repl_len_reg;
      items++;

      if (data == NEWLINE_BYTE) begin
        for (int unsigned i = 0; i < hold_cnt; i++) run.push_back(hold[i]);
        hold_cnt = 0;
        run.push_back(data);
      end else begin
        for (int unsigned i = 0; i < hold_cnt; i++) window[i] = hold[i];
        window[hold_cnt] = data;
        cnt   = hold_cnt + 1;
        first = 0;
        if (cnt == plen && is_prefix(0, cnt)) begin
          for (int unsigned i = 0; i < rlen; i++) run.push_back(repl_word[8*i +: 8]);
          cnt = 0;
          match_count++;
        end else begin
          // Release the oldest bytes until what is left is a proper prefix.
          while (first < cnt) begin
            rest = cnt - first;
            if (rest < plen && is_prefix(first, rest)) break;
            run.push_back(window[first]);
            first++;
          end
        end
        hold_cnt = 0;
        for (int unsigned i = first; i < cnt && hold_cnt < HOLD_DEPTH; i++) begin
          hold[hold_cnt] = window[i];
          hold_cnt++;
        end
      end

      if (eoi) begin
        for (int unsigned i = 0; i < hold_cnt; i++) run.push_back(hold[i]);
        hold_cnt = 0;
      end

      while (run.size() > RUN_BYTES) void'(run.pop_back());
      foreach (run[i]) expected_q.push_back('{data: run[i], last: (i == run.size() - 1)});
    endfunction

    function void check_result(logic [7:0] data, logic last);
      out_beat_t exp_beat;
      checked++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: out_byte %h, out_last_of_run %b", data, last);
        errors++;
        return;
      end
      exp_beat = expected_q.pop_front();
      if (data !== exp_beat.data) begin
        $error("out_byte: expected %h, actual %h", exp_beat.data, data);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $error("out_last_of_run: expected %b, actual %b", exp_beat.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  cfg_reg_t    cfg_index = REG_PATTERN;
  logic [63:0] cfg_wdata = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = '0;
  logic        in_end_of_input = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_of_run;

  rewrite_scoreboard sb = new();
  bit idling_on = 1'b1;
  bit hold_request = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int settings = 0;

  stream_find_replace_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data_byte    (in_data_byte),
    .in_end_of_input (in_end_of_input),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: check every popped transaction, then decide the next pop.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_result(out_byte, out_last_of_run);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("stream_find_replace_core regression: fail");
      $finish;
    end
  end

  function automatic bit random_eoi();
    return $urandom_range(0, 39) == 0;
  endfunction

  task automatic send_byte(logic [7:0] data, logic eoi);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_push         <= 1'b1;
    in_data_byte    <= data;
    in_end_of_input <= eoi;
    do @(posedge clk); while (in_full);
    sb.note_input(data, eoi);
  endtask

  // Bytes that cause no result may still be in flight, so keep clocking the
  // pipeline after the last expected byte has been popped.
  task automatic settle();
    in_push <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  task automatic load_config(logic [63:0] pat, logic [3:0] plen,
                             logic [63:0] repl, logic [3:0] rlen);
    write_reg(REG_PATTERN, pat);
    write_reg(REG_PAT_LEN, {60'd0, plen});
    write_reg(REG_REPL, repl);
    write_reg(REG_REPL_LEN, {60'd0, rlen});
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic run_phase(int p);
    logic [7:0]  letters [3];
    logic [63:0] pat;
    logic [63:0] repl;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    int unsigned eff;
    int unsigned sent;
    int unsigned mode;
    int unsigned k;
    for (int i = 0; i < 3; i++) letters[i] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 5) == 0) letters[2'($urandom_range(0, 2))] = NEWLINE_BYTE;
    // A small alphabet gives patterns that overlap with themselves.
    for (int i = 0; i < 8; i++) pat[8*i +: 8] = letters[2'($urandom_range(0, 2))];
    if ($urandom_range(0, 3) == 0) pat = {$urandom, $urandom};
    repl = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       plen = 4'd0;
      1:       plen = 4'($urandom_range(9, 15));
      default: plen = 4'($urandom_range(1, 8));
    endcase
    rlen = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                       : 4'($urandom_range(0, 8));
    if (p == 0) begin
      pat = '1;
      plen = 4'd8;
      repl = '1;
      rlen = 4'd8;
      letters[0] = 8'hFF;
    end else if (p == 1) begin
      pat = '0;
      plen = 4'd1;
      repl = '0;
      rlen = 4'd0;
      letters[0] = 8'h00;
    end
    eff = (plen == 0) ? 1 : ((plen > 8) ? 8 : plen);

    settle();
    idling_on = (p != PRESSURE_PHASE) && (p < RANDOM_PHASES - 3);
    load_config(pat, plen, repl, rlen);
    if (p == PRESSURE_PHASE) hold_request = 1'b1;

    sent = 0;
    while (sent < PHASE_ITEMS) begin
      mode = $urandom_range(0, 9);
      if (mode <= 4) begin
        k = (mode == 4) ? $urandom_range(1, eff) : eff;
        for (int unsigned i = 0; i < k; i++) send_byte(pat[8*i +: 8], random_eoi());
        sent += k;
      end else begin
        case (mode)
          5, 6, 7: send_byte(letters[2'($urandom_range(0, 2))], random_eoi());
          8:       send_byte(NEWLINE_BYTE, random_eoi());
          default: send_byte(8'($urandom_range(0, 255)), random_eoi());
        endcase
        sent++;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: single zero byte pattern, deleted on a match.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(NEWLINE_BYTE, 1'b0);
    send_byte(8'h00, 1'b1);

    settle();
    load_config(64'h0000_0000_0063_6261, 4'd3, 64'h0000_0000_0000_5958, 4'd2);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(NEWLINE_BYTE, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);

    // Two bytes are still held; they are judged against the new pattern.
    // A zero pattern length acts as one and an oversized replacement saturates.
    settle();
    load_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 64'h8877_6655_4433_2211, 4'd15);
    send_byte(8'h63, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);

    // Oversized pattern length with a newline inside the pattern.
    settle();
    load_config(64'h0000_0000_0000_0A61, 4'd15, 64'h0000_0000_0000_0000, 4'd1);
    send_byte(8'h61, 1'b0);
    send_byte(NEWLINE_BYTE, 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) run_phase(p);

    settle();
    $display("Covered %0d input bytes under %0d register settings.", sb.items, settings);
    $display("Checked %0d output bytes, including %0d pattern matches.",
             sb.checked, sb.match_count);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("stream_find_replace_core regression: pass");
    end else begin
      $display("stream_find_replace_core regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/sfr_pkg.sv
rtl/core/sfr_front.sv
rtl/core/sfr_queue.sv
rtl/core/sfr_back.sv
rtl/core/stream_find_replace_core.sv
tb/stream_find_replace_core_tb.sv
